// ===== rtl/core/pl0sm_pkg.sv =====
// ----------------------------------------------------------------------------
// pl0sm_pkg
// Shared types, codes and sizes for the PL/0 P-code stack machine.
// ----------------------------------------------------------------------------
package pl0sm_pkg;

  localparam int MemWords = 512;
  localparam int MaxLevel = 15;
  localparam int AW       = $clog2(MemWords);      // word address
  localparam int PW       = $clog2(MemWords + 1);  // pointer, may equal MemWords
  localparam int LvW      = $clog2(MaxLevel + 1);  // static-link step count

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LIT  = 4'd1,
    OP_OPR  = 4'd2,
    OP_LOD  = 4'd3,
    OP_STO  = 4'd4,
    OP_CAL  = 4'd5,
    OP_INC  = 4'd6,
    OP_JMP  = 4'd7,
    OP_JPC  = 4'd8,
    OP_SYS  = 4'd9
  } opcode_e;

  typedef enum logic [3:0] {
    OPR_RTN = 4'd0,
    OPR_ADD = 4'd1,
    OPR_SUB = 4'd2,
    OPR_MUL = 4'd3,
    OPR_DIV = 4'd4,
    OPR_EQL = 4'd5,
    OPR_NEQ = 4'd6,
    OPR_LSS = 4'd7,
    OPR_LEQ = 4'd8,
    OPR_GTR = 4'd9,
    OPR_GEQ = 4'd10,
    OPR_ODD = 4'd11
  } opr_e;

  localparam logic [31:0] SysOut  = 32'd1;
  localparam logic [31:0] SysIn   = 32'd2;
  localparam logic [31:0] SysHalt = 32'd3;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_ADDR  = 2'd1,
    FLT_DIV0  = 2'd2,
    FLT_LEVEL = 2'd3
  } fault_e;

  typedef enum logic [4:0] {
    S_IDLE, S_F1, S_F2, S_F3, S_EXEC, S_RA, S_RB, S_CALC, S_DIV, S_ODD,
    S_WALK, S_WALK2, S_ADDR, S_LOD2, S_STO2, S_CAL2, S_CAL3, S_JPC2,
    S_OUT2, S_DONE
  } state_e;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [31:0]   wdata;
  } mem_req_t;

  // signed 32-bit word lies inside the memory
  function automatic logic in_mem32(input logic [31:0] x);
    return !x[31] && (x < 32'(MemWords));
  endfunction

  function automatic logic in_mem34(input logic [33:0] x);
    return !x[33] && (x < 34'(MemWords));
  endfunction

endpackage

// ===== rtl/core/pl0_stack_machine_step.sv =====
// ----------------------------------------------------------------------------
// pl0_stack_machine_step
// PL/0 P-code machine: one request loads a word or executes one instruction.
// ----------------------------------------------------------------------------
// Sequence: a load, an execute while stopped or a fetch fault goes straight to its
//   result; an instruction fetches three words, executes, and may walk static links
//   (LOD/STO/CAL) or run the divider. A stalled result holds the next request.
// Requests: one at a time, limited by the single memory port
//   (three fetch reads plus stack reads and writes) and the serial divider.
// Reset: pc 0, bp MemWords-1, sp MemWords, not stopped, no fault; memory
//   content is undefined until written.
module pl0_stack_machine_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // load_address[8:0], load_value[40:9], input_value[72:41]
  input  logic        s_tuser,  // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // pc_after[8:0], bp_after[18:9], sp_after[28:19],
                                // opcode_done[32:29], out_valid[33], out_value[65:34],
                                // input_taken[66], halted[67], fault[69:68]
);
  import pl0sm_pkg::*;

  state_e       state_q, state_d;
  logic [PW-1:0] pc_q, pc_d, bp_q, bp_d, sp_q, sp_d;
  logic         stopped_q, stopped_d;
  fault_e       fault_q, fault_d;
  opcode_e      op_q, op_d;
  logic         op_ok_q, op_ok_d, lev_big_q, lev_big_d;
  logic [LvW-1:0] cnt_q, cnt_d;
  logic [31:0]  m_q, m_d, a_q, a_d, b_q, b_d, arb_q, arb_d, inval_q, inval_d;
  logic [AW-1:0] ea_q, ea_d;
  logic [3:0]   opd_q, opd_d;
  logic         ov_q, ov_d, taken_q, taken_d;
  logic [31:0]  oval_q, oval_d;
  logic         m_tvalid_q;
  logic [71:0]  m_tdata_q;

  mem_req_t     mreq;
  logic [31:0]  rdata, alu_r, div_q;
  logic         div_start, div_done;

  logic [PW-1:0] mem_w, sp_m1, sp_p1, pc_p3;
  logic [33:0]  ea_w, inc_w;
  logic         flt_set, out_load;
  fault_e       flt_code;

  pl0sm_mem u_mem (.clk_i, .req_i(mreq), .rdata_o(rdata));
  pl0sm_alu u_alu (.op_i(opr_e'(m_q[3:0])), .a_i(a_q), .b_i(b_q), .r_o(alu_r));
  pl0sm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(a_q), .b_i(b_q),
    .done_o(div_done), .q_o(div_q)
  );

  assign mem_w = PW'(MemWords);
  assign sp_m1 = sp_q - PW'(1);
  assign sp_p1 = sp_q + PW'(1);
  assign pc_p3 = pc_q + PW'(3);
  assign ea_w  = {{2{arb_q[31]}}, arb_q} - {{2{m_q[31]}}, m_q};
  assign inc_w = 34'(sp_q) - {{2{m_q[31]}}, m_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pc_q       <= '0;
      bp_q       <= PW'(MemWords - 1);
      sp_q       <= PW'(MemWords);
      stopped_q  <= 1'b0;
      fault_q    <= FLT_NONE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      bp_q      <= bp_d;
      sp_q      <= sp_d;
      stopped_q <= stopped_d;
      fault_q   <= fault_d;
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    op_ok_q   <= op_ok_d;
    lev_big_q <= lev_big_d;
    cnt_q     <= cnt_d;
    m_q       <= m_d;
    a_q       <= a_d;
    b_q       <= b_d;
    arb_q     <= arb_d;
    inval_q   <= inval_d;
    ea_q      <= ea_d;
    opd_q     <= opd_d;
    ov_q      <= ov_d;
    oval_q    <= oval_d;
    taken_q   <= taken_d;
    if (out_load) begin
      m_tdata_q <= {2'b00, fault_q, stopped_q, taken_q, oval_q, ov_q, opd_q,
                    10'(sp_q), 10'(bp_q), 9'(pc_q)};
    end
  end

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    bp_d      = bp_q;
    sp_d      = sp_q;
    stopped_d = stopped_q;
    fault_d   = fault_q;
    op_d      = op_q;
    op_ok_d   = op_ok_q;
    lev_big_d = lev_big_q;
    cnt_d     = cnt_q;
    m_d       = m_q;
    a_d       = a_q;
    b_d       = b_q;
    arb_d     = arb_q;
    inval_d   = inval_q;
    ea_d      = ea_q;
    opd_d     = opd_q;
    ov_d      = ov_q;
    oval_d    = oval_q;
    taken_d   = taken_q;
    mreq      = '{we: 1'b0, addr: '0, wdata: '0};
    div_start = 1'b0;
    s_tready  = 1'b0;
    out_load  = 1'b0;
    flt_set   = 1'b0;
    flt_code  = FLT_ADDR;

    unique case (state_q)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          inval_d = s_tdata[72:41];
          opd_d   = 4'(OP_NONE);
          ov_d    = 1'b0;
          oval_d  = '0;
          taken_d = 1'b0;
          state_d = S_DONE;
          if (!s_tuser) begin
            if (32'(s_tdata[8:0]) < 32'(MemWords)) begin
              mreq = '{we: 1'b1, addr: AW'(s_tdata[8:0]), wdata: s_tdata[40:9]};
            end
          end else if (!stopped_q) begin
            if (32'(pc_q) + 32'd2 >= 32'(MemWords)) begin
              flt_set = 1'b1;
            end else begin
              mreq.addr = AW'(pc_q);
              state_d   = S_F1;
            end
          end
        end
      end
      S_F1: begin
        op_ok_d   = (rdata >= 32'(OP_LIT)) && (rdata <= 32'(OP_SYS));
        op_d      = opcode_e'(rdata[3:0]);
        mreq.addr = AW'(pc_q + PW'(1));
        state_d   = S_F2;
      end
      S_F2: begin
        lev_big_d = rdata > 32'(MaxLevel);
        cnt_d     = LvW'(rdata);
        mreq.addr = AW'(pc_q + PW'(2));
        state_d   = S_F3;
      end
      S_F3: begin
        m_d     = rdata;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        if (!op_ok_q) begin
          pc_d = pc_p3;
        end else begin
          opd_d = 4'(op_q);
          unique case (op_q)
            OP_LIT: begin
              if (sp_q == '0) flt_set = 1'b1;
              else begin
                mreq = '{we: 1'b1, addr: AW'(sp_m1), wdata: m_q};
                sp_d = sp_m1;
                pc_d = pc_p3;
              end
            end
            OP_OPR: begin
              if (m_q == 32'(OPR_RTN)) begin
                if (bp_q < PW'(2)) flt_set = 1'b1;
                else begin
                  mreq.addr = AW'(bp_q - PW'(1));
                  state_d   = S_RA;
                end
              end else if (m_q >= 32'(OPR_ADD) && m_q <= 32'(OPR_GEQ)) begin
                if (sp_p1 >= mem_w) flt_set = 1'b1;
                else begin
                  mreq.addr = AW'(sp_p1);
                  state_d   = S_RA;
                end
              end else if (m_q == 32'(OPR_ODD)) begin
                if (sp_q >= mem_w) flt_set = 1'b1;
                else begin
                  mreq.addr = AW'(sp_q);
                  state_d   = S_ODD;
                end
              end else begin
                pc_d = pc_p3;
              end
            end
            OP_LOD, OP_STO, OP_CAL: begin
              if (lev_big_q) begin
                flt_set  = 1'b1;
                flt_code = FLT_LEVEL;
              end else begin
                arb_d   = 32'(bp_q);
                state_d = S_WALK;
              end
            end
            OP_INC: begin
              if (inc_w[33] || inc_w > 34'(MemWords)) flt_set = 1'b1;
              else begin
                sp_d = PW'(inc_w);
                pc_d = pc_p3;
              end
            end
            OP_JMP: begin
              if (!in_mem32(m_q)) flt_set = 1'b1;
              else pc_d = PW'(m_q);
            end
            OP_JPC: begin
              if (sp_q >= mem_w) flt_set = 1'b1;
              else begin
                mreq.addr = AW'(sp_q);
                state_d   = S_JPC2;
              end
            end
            OP_SYS: begin
              if (m_q == SysOut) begin
                if (sp_q >= mem_w) flt_set = 1'b1;
                else begin
                  mreq.addr = AW'(sp_q);
                  state_d   = S_OUT2;
                end
              end else if (m_q == SysIn) begin
                if (sp_q == '0) flt_set = 1'b1;
                else begin
                  mreq    = '{we: 1'b1, addr: AW'(sp_m1), wdata: inval_q};
                  sp_d    = sp_m1;
                  pc_d    = pc_p3;
                  taken_d = 1'b1;
                end
              end else begin
                if (m_q == SysHalt) stopped_d = 1'b1;
                pc_d = pc_p3;
              end
            end
            default: pc_d = pc_p3;
          endcase
        end
      end
      S_RA: begin
        a_d       = rdata;
        mreq.addr = (m_q == 32'(OPR_RTN)) ? AW'(bp_q - PW'(2)) : AW'(sp_q);
        state_d   = S_RB;
      end
      S_RB: begin
        b_d     = rdata;
        state_d = S_CALC;
      end
      S_CALC: begin
        state_d = S_DONE;
        if (m_q == 32'(OPR_RTN)) begin
          if (!in_mem32(a_q) || !in_mem32(b_q)) flt_set = 1'b1;
          else begin
            sp_d = bp_q + PW'(1);
            bp_d = PW'(a_q);
            pc_d = PW'(b_q);
          end
        end else if (m_q == 32'(OPR_DIV)) begin
          if (b_q == '0) begin
            flt_set  = 1'b1;
            flt_code = FLT_DIV0;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end else begin
          mreq = '{we: 1'b1, addr: AW'(sp_p1), wdata: alu_r};
          sp_d = sp_p1;
          pc_d = pc_p3;
        end
      end
      S_DIV: begin
        if (div_done) begin
          mreq    = '{we: 1'b1, addr: AW'(sp_p1), wdata: div_q};
          sp_d    = sp_p1;
          pc_d    = pc_p3;
          state_d = S_DONE;
        end
      end
      S_ODD: begin
        mreq    = '{we: 1'b1, addr: AW'(sp_q), wdata: {31'd0, rdata[0]}};
        pc_d    = pc_p3;
        state_d = S_DONE;
      end
      S_WALK: begin
        if (cnt_q == '0) begin
          state_d = S_ADDR;
        end else if (!in_mem32(arb_q)) begin
          flt_set = 1'b1;
        end else begin
          mreq.addr = AW'(arb_q);
          state_d   = S_WALK2;
        end
      end
      S_WALK2: begin
        arb_d   = rdata;
        cnt_d   = cnt_q - LvW'(1);
        state_d = S_WALK;
      end
      S_ADDR: begin
        state_d = S_DONE;
        if (op_q == OP_CAL) begin
          if (sp_q < PW'(3) || !in_mem32(m_q)) flt_set = 1'b1;
          else begin
            mreq    = '{we: 1'b1, addr: AW'(sp_m1), wdata: arb_q};
            state_d = S_CAL2;
          end
        end else if (!in_mem34(ea_w)) begin
          flt_set = 1'b1;
        end else if (op_q == OP_LOD) begin
          if (sp_q == '0) flt_set = 1'b1;
          else begin
            mreq.addr = AW'(ea_w);
            state_d   = S_LOD2;
          end
        end else begin
          if (sp_q >= mem_w) flt_set = 1'b1;
          else begin
            ea_d      = AW'(ea_w);
            mreq.addr = AW'(sp_q);
            state_d   = S_STO2;
          end
        end
      end
      S_LOD2: begin
        mreq    = '{we: 1'b1, addr: AW'(sp_m1), wdata: rdata};
        sp_d    = sp_m1;
        pc_d    = pc_p3;
        state_d = S_DONE;
      end
      S_STO2: begin
        mreq    = '{we: 1'b1, addr: ea_q, wdata: rdata};
        sp_d    = sp_p1;
        pc_d    = pc_p3;
        state_d = S_DONE;
      end
      S_CAL2: begin
        mreq    = '{we: 1'b1, addr: AW'(sp_q - PW'(2)), wdata: 32'(bp_q)};
        state_d = S_CAL3;
      end
      S_CAL3: begin
        mreq    = '{we: 1'b1, addr: AW'(sp_q - PW'(3)), wdata: 32'(pc_p3)};
        bp_d    = sp_m1;
        pc_d    = PW'(m_q);
        state_d = S_DONE;
      end
      S_JPC2: begin
        state_d = S_DONE;
        if (rdata == '0 && !in_mem32(m_q)) flt_set = 1'b1;
        else begin
          pc_d = (rdata == '0) ? PW'(m_q) : pc_p3;
          sp_d = sp_p1;
        end
      end
      S_OUT2: begin
        ov_d    = 1'b1;
        oval_d  = rdata;
        sp_d    = sp_p1;
        pc_d    = pc_p3;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid_q || m_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a faulting instruction leaves memory and pointers alone
    if (flt_set) begin
      stopped_d = 1'b1;
      fault_d   = flt_code;
      state_d   = S_DONE;
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;

  a_fault_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_q != FLT_NONE) |-> stopped_q)
    else $error("fault set without stop");

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("stopped flag cleared");

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= PW'(MemWords))
    else $error("sp beyond memory");

  a_bp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bp_q < PW'(MemWords))
    else $error("bp beyond memory");

endmodule

// ===== rtl/core/pl0sm_mem.sv =====
// ----------------------------------------------------------------------------
// pl0sm_mem
// Single-port word memory for code and stack, registered read data.
// ----------------------------------------------------------------------------
module pl0sm_mem (
  input  logic              clk_i,
  input  pl0sm_pkg::mem_req_t req_i,
  output logic [31:0]       rdata_o
);
  import pl0sm_pkg::*;

  logic [31:0] mem_q [MemWords];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[req_i.addr];
  end

endmodule

// ===== rtl/core/pl0sm_div.sv =====
// ----------------------------------------------------------------------------
// pl0sm_div
// Radix-2 restoring signed divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pl0sm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] q_o
);
  import pl0sm_pkg::*;

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic        neg_q;
  logic [31:0] rem_q, quo_q, div_q;
  logic [32:0] shifted;
  logic        ge;

  assign shifted = {rem_q, quo_q[31]};
  assign ge      = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 6'd1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= a_i[31] ? 32'(-a_i) : a_i;
      div_q <= b_i[31] ? 32'(-b_i) : b_i;
      neg_q <= a_i[31] ^ b_i[31];
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= ge ? 32'(shifted - {1'b0, div_q}) : shifted[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign q_o    = neg_q ? 32'(-quo_q) : quo_q;

endmodule

// ===== rtl/core/pl0sm_alu.sv =====
// ----------------------------------------------------------------------------
// pl0sm_alu
// Shared arithmetic and compare unit for the OPR add, subtract, multiply and compares.
// ----------------------------------------------------------------------------
module pl0sm_alu (
  input  pl0sm_pkg::opr_e op_i,
  input  logic [31:0]     a_i,
  input  logic [31:0]     b_i,
  output logic [31:0]     r_o
);
  import pl0sm_pkg::*;

  logic signed [31:0] sa, sb;
  assign sa = a_i;
  assign sb = b_i;

  always_comb begin
    unique case (op_i)
      OPR_ADD: r_o = a_i + b_i;
      OPR_SUB: r_o = a_i - b_i;
      OPR_MUL: r_o = 32'(a_i * b_i);
      OPR_EQL: r_o = {31'd0, sa == sb};
      OPR_NEQ: r_o = {31'd0, sa != sb};
      OPR_LSS: r_o = {31'd0, sa <  sb};
      OPR_LEQ: r_o = {31'd0, sa <= sb};
      OPR_GTR: r_o = {31'd0, sa >  sb};
      OPR_GEQ: r_o = {31'd0, sa >= sb};
      default: r_o = '0;
    endcase
  end

endmodule
